// ===== hw/rtl/irrt_pkg.sv =====
// Shared types and codes for the I/O range reservation table.
package irrt_pkg;

	localparam int ADDR_W = 32;
	localparam int KIND_W = 2;
	localparam int SLOT_W = 4;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_OVERLAP   = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_MISMATCH  = 3'd4
	} status_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] count;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
	} res_t;

endpackage

// ===== hw/rtl/irrt_mem.sv =====
// Single-port-write, single-port-read table memory with registered read data.
module irrt_mem #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4,
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/irrt_scan.sv =====
// Scan sequencer: walks the table once per request and commits the outcome.
module irrt_scan import irrt_pkg::*; #(
	parameter int ENTRIES = 16,
	parameter int IDX_W   = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  req_t                req,
	output logic                res_valid,
	input  logic                res_ready,
	output res_t                res,
	output logic                rd_en,
	output logic [IDX_W-1:0]    rd_addr,
	input  logic [2*ADDR_W-1:0] rd_data,
	output logic                wr_en,
	output logic [IDX_W-1:0]    wr_addr,
	output logic [2*ADDR_W-1:0] wr_data
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    ra_q;
	logic                vld_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [KIND_W-1:0]   kind_q;
	logic [ADDR_W-1:0]   start_q;
	logic [ADDR_W-1:0]   end_q;
	logic [ENTRIES-1:0]  occ_q;
	logic                overlap_q;
	logic                free_fnd_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic                match_fnd_q;
	logic [IDX_W-1:0]    match_idx_q;
	logic                match_eq_q;

	logic                ent_occ;
	logic [ADDR_W-1:0]   ent_start;
	logic [ADDR_W-1:0]   ent_end;
	logic                commit;
	logic                do_alloc;
	logic                do_free;

	assign ent_occ   = occ_q[idx_s1];
	assign ent_start = rd_data[ADDR_W-1:0];
	assign ent_end   = rd_data[2*ADDR_W-1:ADDR_W];

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign rd_en     = (state_q == S_SCAN);
	assign rd_addr   = ra_q;

	// Decide the outcome from the scan flags
	always_comb begin
		res.status = ST_OK;
		res.slot   = '0;
		do_alloc   = 1'b0;
		do_free    = 1'b0;
		case (kind_q)
			KIND_ALLOC: begin
				if (overlap_q) begin
					res.status = ST_OVERLAP;
				end else if (free_fnd_q) begin
					res.slot = SLOT_W'(free_idx_q);
					do_alloc = 1'b1;
				end else begin
					res.status = ST_FULL;
				end
			end
			KIND_RELEASE: begin
				if (!match_fnd_q) begin
					res.status = ST_NOT_FOUND;
				end else if (match_eq_q) begin
					res.slot = SLOT_W'(match_idx_q);
					do_free  = 1'b1;
				end else begin
					res.status = ST_MISMATCH;
					res.slot   = SLOT_W'(match_idx_q);
				end
			end
			default: begin
				res.status = overlap_q ? ST_OVERLAP : ST_OK;
			end
		endcase
	end

	assign commit  = (state_q == S_DONE) && res_ready;
	assign wr_en   = commit && do_alloc;
	assign wr_addr = free_idx_q;
	assign wr_data = {end_q, start_q};

	// Sequencer, compare stage and occupancy bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ra_q        <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			occ_q       <= '0;
			overlap_q   <= 1'b0;
			free_fnd_q  <= 1'b0;
			match_fnd_q <= 1'b0;
			kind_q      <= KIND_QUERY;
			start_q     <= '0;
			end_q       <= '0;
			free_idx_q  <= '0;
			match_idx_q <= '0;
			match_eq_q  <= 1'b0;
		end else begin
			vld_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						kind_q      <= req.kind;
						start_q     <= req.start;
						end_q       <= req.start + req.count;
						ra_q        <= '0;
						overlap_q   <= 1'b0;
						free_fnd_q  <= 1'b0;
						match_fnd_q <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					vld_s1 <= 1'b1;
					idx_s1 <= ra_q;
					if (ra_q == LAST_IDX) begin
						state_q <= S_DRAIN;
					end else begin
						ra_q <= ra_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Compare the entry read last cycle against the request
			if (vld_s1) begin
				if (ent_occ && (ent_start < end_q) && (ent_end > start_q)) begin
					overlap_q <= 1'b1;
				end
				if (!ent_occ && !free_fnd_q) begin
					free_fnd_q <= 1'b1;
					free_idx_q <= idx_s1;
				end
				if (ent_occ && (ent_start == start_q) && !match_fnd_q) begin
					match_fnd_q <= 1'b1;
					match_idx_q <= idx_s1;
					match_eq_q  <= (ent_end == end_q);
				end
			end

			// Commit table changes as the result leaves
			if (wr_en) begin
				occ_q[free_idx_q] <= (start_q != end_q);
			end
			if (commit && do_free) begin
				occ_q[match_idx_q] <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/io_range_reservation_table.sv =====
// Top level of the I/O range reservation table.
//
// channel   | signals                 | beat contents (low bit first)
// ----------+-------------------------+--------------------------------------------
// request   | s_axis_t{valid,ready}   | tuser: kind[1:0]; tdata: range_start[31:0],
//           |                         |        range_count[63:32]
// result    | m_axis_t{valid,ready}   | tdata: status[2:0], slot[6:3], zero[7]
//
// Each request passes through these steps in order: accept, one table read per
// entry through the single read port of the table memory, the last compare, and
// the result hand-over, which waits until the output register can take it.
// Reset clears the occupancy bits at once; every entry reads as empty after it.
// A held result in the output register does not stop the next request from
// being accepted and scanned; the scan waits only to hand over its own result.
module io_range_reservation_table import irrt_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // range_start[31:0], range_count[63:32]
	input  logic [1:0]  s_axis_tuser,   // kind[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // status[2:0], slot[6:3], zero[7]
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	req_t                req;
	res_t                res;
	logic                res_vld;
	logic                res_rdy;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic [2*ADDR_W-1:0] rd_data;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [2*ADDR_W-1:0] wr_data;
	logic                out_vld_q;
	res_t                out_q;

	assign req.kind  = s_axis_tuser;
	assign req.start = s_axis_tdata[ADDR_W-1:0];
	assign req.count = s_axis_tdata[2*ADDR_W-1:ADDR_W];

	irrt_mem #(
		.DEPTH  (ENTRIES),
		.ADDR_W (IDX_W),
		.DATA_W (2*ADDR_W)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	irrt_scan #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req       (req),
		.res_valid (res_vld),
		.res_ready (res_rdy),
		.res       (res),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// Hold the result beat until the sink takes it
	assign res_rdy = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_rdy) begin
			out_vld_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld && res_rdy) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {1'b0, out_q.slot, out_q.status};

`ifndef SYNTHESIS
	// A finished scan result lands in the output register
	a_res_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld && res_rdy) |=> m_axis_tvalid)
		else $error("result handed over but output register not loaded");

	// No request is taken while the scan still holds a result
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !res_vld)
		else $error("request accepted while a result is pending");

	// Slot is reported only for ok or length-mismatch outcomes
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[2:0] != ST_OK) && (m_axis_tdata[2:0] != ST_MISMATCH))
		|-> (m_axis_tdata[6:3] == '0))
		else $error("slot set on a failed request");
`endif

endmodule
